FILE: rtl/vfcm_pkg.sv
// shared types, constants and codes of the voxel face culling mesher
package vfcm_pkg;

  localparam int CHUNK_DIM_DEF  = 32;
  localparam int ATLAS_COLS_DEF = 4;
  localparam int ATLAS_ROWS_DEF = 4;

  localparam int MODE_W   = 2;
  localparam int COORD_W  = 5;
  localparam int BLOCK_W  = 8;
  localparam int CORNER_W = 6;
  localparam int AXIS_W   = 2;
  localparam int TILE_W   = 2;
  localparam int BASE_W   = 20;

  localparam int NUM_FACES = 6;
  localparam int FACE_W    = 3;
  localparam int STEP_W    = 3;
  // center read plus one read per face
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_FACES);

  localparam logic [BASE_W-1:0] VERTS_PER_QUAD = BASE_W'(4);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_MESH  = 2'd1,
    MODE_NEW   = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] voxel_x;
    logic [COORD_W-1:0] voxel_y;
    logic [COORD_W-1:0] voxel_z;
    logic [BLOCK_W-1:0] block_value;
  } in_item_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
    logic [CORNER_W-1:0] corner_z;
    logic [AXIS_W-1:0]   face_axis;
    logic                positive_side;
    logic [TILE_W-1:0]   tile_col;
    logic [TILE_W-1:0]   tile_row;
    logic [BASE_W-1:0]   base_vertex;
    logic                last;
  } out_item_t;

  // quad as built by the sequencer, before the atlas lookup
  typedef struct packed {
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
    logic [CORNER_W-1:0] corner_z;
    logic [AXIS_W-1:0]   face_axis;
    logic                positive_side;
    logic [BASE_W-1:0]   base_vertex;
    logic                last;
  } quad_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: rtl/vfcm_store.sv
// single-port voxel chunk store with registered read data
module vfcm_store #(
  parameter int CHUNK_DIM = vfcm_pkg::CHUNK_DIM_DEF
) (
  input  logic                         clk_i,
  input  vfcm_pkg::mem_ctl_t           ctl_i,
  input  logic [$clog2(CHUNK_DIM*CHUNK_DIM*CHUNK_DIM)-1:0] addr_i,
  input  logic [vfcm_pkg::BLOCK_W-1:0] wdata_i,
  output logic [vfcm_pkg::BLOCK_W-1:0] rdata_o
);

  localparam int DEPTH = CHUNK_DIM * CHUNK_DIM * CHUNK_DIM;

  logic [vfcm_pkg::BLOCK_W-1:0] mem [DEPTH];
  logic [vfcm_pkg::BLOCK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/vfcm_ctrl.sv
// sequencer: address unit, neighbor reads, face visibility and quad emission
module vfcm_ctrl #(
  parameter int CHUNK_DIM = vfcm_pkg::CHUNK_DIM_DEF,
  localparam int AW       = $clog2(CHUNK_DIM*CHUNK_DIM*CHUNK_DIM)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  vfcm_pkg::in_item_t           item_i,
  output logic                         busy_o,
  output vfcm_pkg::mem_ctl_t           mem_ctl_o,
  output logic [AW-1:0]                mem_addr_o,
  output logic [vfcm_pkg::BLOCK_W-1:0] mem_wdata_o,
  input  logic [vfcm_pkg::BLOCK_W-1:0] mem_rdata_i,
  output vfcm_pkg::quad_t              quad_o,
  output logic                         quad_valid_o,
  output logic [vfcm_pkg::BLOCK_W-1:0] block_o
);

  localparam logic [AW-1:0] DIM_A   = AW'(CHUNK_DIM);
  localparam logic [AW-1:0] PLANE_A = AW'(CHUNK_DIM * CHUNK_DIM);
  localparam logic [AW-1:0] ONE_A   = AW'(1);
  localparam logic [vfcm_pkg::COORD_W+1:0] DIM_C = (vfcm_pkg::COORD_W+2)'(CHUNK_DIM);
  localparam logic [vfcm_pkg::COORD_W:0] EDGE_C = (vfcm_pkg::COORD_W+1)'(CHUNK_DIM - 1);

  vfcm_pkg::state_e state_q, state_d;
  vfcm_pkg::in_item_t cmd_q, cmd_d;

  logic [AW-1:0] row_q, row_d;
  logic [AW-1:0] cell_q, cell_d;
  logic [vfcm_pkg::STEP_W-1:0] step_q, step_d;
  logic rd_vld_q, rd_vld_d;
  logic [vfcm_pkg::STEP_W-1:0] rd_step_q, rd_step_d;
  logic rd_out_q, rd_out_d;
  logic [vfcm_pkg::NUM_FACES-1:0] vis_q, vis_d;
  logic [vfcm_pkg::BLOCK_W-1:0] center_q, center_d;
  logic [vfcm_pkg::BASE_W-1:0] cnt_q, cnt_d;
  vfcm_pkg::quad_t quad_q, quad_d;
  logic quad_vld_q, quad_vld_d;

  logic accept;
  logic in_range;

  // shared multiply-add unit: a * CHUNK_DIM + b
  logic [AW-1:0] mac_a, mac_b, mac_y;

  // issue side face decode
  logic [vfcm_pkg::FACE_W-1:0] iss_face;
  logic [vfcm_pkg::AXIS_W-1:0] iss_axis;
  logic [vfcm_pkg::COORD_W-1:0] iss_coord;
  logic [AW-1:0] iss_ofs;
  logic iss_out;
  logic [AW-1:0] iss_addr;

  // emit side face pick
  logic [vfcm_pkg::NUM_FACES-1:0] low_bit, rem_vis;
  logic [vfcm_pkg::FACE_W-1:0] emit_face;
  logic [vfcm_pkg::AXIS_W-1:0] emit_axis;
  logic emit_side;

  assign busy_o   = (state_q != vfcm_pkg::ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign in_range = ({2'b00, item_i.voxel_x} < DIM_C) &&
                    ({2'b00, item_i.voxel_y} < DIM_C) &&
                    ({2'b00, item_i.voxel_z} < DIM_C);

  assign mac_y = mac_a * DIM_A + mac_b;

  always_comb begin
    if (state_q == vfcm_pkg::ST_ROW) begin
      mac_a = AW'(cmd_q.voxel_x);
      mac_b = AW'(cmd_q.voxel_y);
    end else begin
      mac_a = row_q;
      mac_b = AW'(cmd_q.voxel_z);
    end
  end

  // neighbor of the face being read: step 0 is the voxel itself
  always_comb begin
    iss_face = vfcm_pkg::FACE_W'(step_q - vfcm_pkg::STEP_W'(1));
    iss_axis = iss_face[2:1];
    unique case (iss_axis)
      vfcm_pkg::AXIS_X: begin
        iss_coord = cmd_q.voxel_x;
        iss_ofs   = PLANE_A;
      end
      vfcm_pkg::AXIS_Y: begin
        iss_coord = cmd_q.voxel_y;
        iss_ofs   = DIM_A;
      end
      default: begin
        iss_coord = cmd_q.voxel_z;
        iss_ofs   = ONE_A;
      end
    endcase
    if (step_q == '0) begin
      iss_out  = 1'b0;
      iss_addr = cell_q;
    end else if (iss_face[0]) begin
      iss_out  = ({1'b0, iss_coord} == EDGE_C);
      iss_addr = cell_q + iss_ofs;
    end else begin
      iss_out  = (iss_coord == '0);
      iss_addr = cell_q - iss_ofs;
    end
  end

  // lowest pending face goes first, which is axis order, negative side first
  always_comb begin
    low_bit   = vis_q & (~vis_q + vfcm_pkg::NUM_FACES'(1));
    rem_vis   = vis_q & ~low_bit;
    emit_face = '0;
    for (int i = 0; i < vfcm_pkg::NUM_FACES; i++) begin
      if (low_bit[i]) begin
        emit_face = vfcm_pkg::FACE_W'(i);
      end
    end
    emit_axis = emit_face[2:1];
    emit_side = emit_face[0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfcm_pkg::ST_IDLE: begin
        if (accept && in_range && (item_i.mode == vfcm_pkg::MODE_WRITE ||
                                   item_i.mode == vfcm_pkg::MODE_MESH)) begin
          state_d = vfcm_pkg::ST_ROW;
        end
      end
      vfcm_pkg::ST_ROW: state_d = vfcm_pkg::ST_CELL;
      vfcm_pkg::ST_CELL: begin
        state_d = (cmd_q.mode == vfcm_pkg::MODE_WRITE) ? vfcm_pkg::ST_WRITE
                                                       : vfcm_pkg::ST_READ;
      end
      vfcm_pkg::ST_WRITE: state_d = vfcm_pkg::ST_IDLE;
      vfcm_pkg::ST_READ: begin
        if (step_q == vfcm_pkg::LAST_STEP) begin
          state_d = vfcm_pkg::ST_DRAIN;
        end
      end
      vfcm_pkg::ST_DRAIN: begin
        state_d = (center_q != '0 && vis_d != '0) ? vfcm_pkg::ST_EMIT : vfcm_pkg::ST_IDLE;
      end
      vfcm_pkg::ST_EMIT: begin
        if (rem_vis == '0) begin
          state_d = vfcm_pkg::ST_IDLE;
        end
      end
      default: state_d = vfcm_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    row_d       = row_q;
    cell_d      = cell_q;
    step_d      = step_q;
    rd_vld_d    = 1'b0;
    rd_step_d   = step_q;
    rd_out_d    = iss_out;
    vis_d       = vis_q;
    center_d    = center_q;
    cnt_d       = cnt_q;
    quad_d      = quad_q;
    quad_vld_d  = 1'b0;
    mem_ctl_o   = '0;
    mem_addr_o  = cell_q;
    mem_wdata_o = cmd_q.block_value;

    // read data lands in the cycle after its address
    if (rd_vld_q) begin
      if (rd_step_q == '0) begin
        center_d = mem_rdata_i;
      end else begin
        vis_d[vfcm_pkg::FACE_W'(rd_step_q - vfcm_pkg::STEP_W'(1))] =
          rd_out_q || (mem_rdata_i == '0);
      end
    end

    unique case (state_q)
      vfcm_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d = item_i;
          if (item_i.mode == vfcm_pkg::MODE_NEW) begin
            cnt_d = '0;
          end
        end
      end
      vfcm_pkg::ST_ROW: row_d = mac_y;
      vfcm_pkg::ST_CELL: begin
        cell_d = mac_y;
        step_d = '0;
      end
      vfcm_pkg::ST_WRITE: mem_ctl_o.wr_en = 1'b1;
      vfcm_pkg::ST_READ: begin
        mem_addr_o      = iss_addr;
        mem_ctl_o.rd_en = !iss_out;
        rd_vld_d        = 1'b1;
        step_d          = step_q + vfcm_pkg::STEP_W'(1);
      end
      vfcm_pkg::ST_DRAIN: ;
      vfcm_pkg::ST_EMIT: begin
        quad_vld_d           = 1'b1;
        quad_d.corner_x      = vfcm_pkg::CORNER_W'(cmd_q.voxel_x) +
          vfcm_pkg::CORNER_W'(emit_side && emit_axis == vfcm_pkg::AXIS_X);
        quad_d.corner_y      = vfcm_pkg::CORNER_W'(cmd_q.voxel_y) +
          vfcm_pkg::CORNER_W'(emit_side && emit_axis == vfcm_pkg::AXIS_Y);
        quad_d.corner_z      = vfcm_pkg::CORNER_W'(cmd_q.voxel_z) +
          vfcm_pkg::CORNER_W'(emit_side && emit_axis == vfcm_pkg::AXIS_Z);
        quad_d.face_axis     = emit_axis;
        quad_d.positive_side = emit_side;
        quad_d.base_vertex   = cnt_q;
        quad_d.last          = (rem_vis == '0);
        cnt_d                = cnt_q + vfcm_pkg::VERTS_PER_QUAD;
        vis_d                = rem_vis;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vfcm_pkg::ST_IDLE;
      step_q     <= '0;
      rd_vld_q   <= 1'b0;
      cnt_q      <= '0;
      quad_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      rd_vld_q   <= rd_vld_d;
      cnt_q      <= cnt_d;
      quad_vld_q <= quad_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    row_q     <= row_d;
    cell_q    <= cell_d;
    rd_step_q <= rd_step_d;
    rd_out_q  <= rd_out_d;
    vis_q     <= vis_d;
    center_q  <= center_d;
    quad_q    <= quad_d;
  end

  assign quad_o       = quad_q;
  assign quad_valid_o = quad_vld_q;
  assign block_o      = center_q;

endmodule

FILE: rtl/voxel_face_culling_mesher_unit.sv
// Voxel face-culling mesher: chunk store, sequencer and atlas tile lookup.
//
// Commands enter on in_i and are taken at a clock edge where start_i is high
// and busy_o is low. Mode 0 writes one voxel, mode 2 clears the vertex
// counter, mode 1 meshes one voxel, mode 3 is dropped.
// Mode 0 with the voxel inside the chunk keeps busy_o high through two multiply-add
// steps for the store address (ROW, CELL), then the write.
// Mode 1 inside the chunk: two address steps, 7 reads of the single store port
// (the voxel and its six neighbors; a neighbor outside the chunk is not read), a
// drain state for the last read data, then, for a nonzero voxel, one quad per
// visible face at one quad per cycle, the final one flagged by last. Modes 2 and 3
// and coordinates outside the chunk do not raise busy_o. The store port sets the rate.
// Each quad is on result_o for exactly one cycle with result_valid_o high;
// the receiver cannot stall, so results are never held back.
// Reset clears the sequencer and the vertex counter; the store content is
// undefined until written, and every voxel must be written before a mesh
// command reads it or its neighbors.
module voxel_face_culling_mesher_unit #(
  parameter int CHUNK_DIM  = vfcm_pkg::CHUNK_DIM_DEF,
  parameter int ATLAS_COLS = vfcm_pkg::ATLAS_COLS_DEF,
  parameter int ATLAS_ROWS = vfcm_pkg::ATLAS_ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  vfcm_pkg::in_item_t  in_i,
  output logic                busy_o,
  output vfcm_pkg::out_item_t result_o,
  output logic                result_valid_o
);

  localparam int AW        = $clog2(CHUNK_DIM*CHUNK_DIM*CHUNK_DIM);
  localparam int MAX_TILE  = ATLAS_COLS * ATLAS_ROWS - 1;
  localparam int LUT_DEPTH = 2 ** vfcm_pkg::BLOCK_W;

  vfcm_pkg::mem_ctl_t           mem_ctl;
  logic [AW-1:0]                mem_addr;
  logic [vfcm_pkg::BLOCK_W-1:0] mem_wdata;
  logic [vfcm_pkg::BLOCK_W-1:0] mem_rdata;
  vfcm_pkg::quad_t              quad;
  logic                         quad_valid;
  logic [vfcm_pkg::BLOCK_W-1:0] block;

  logic [vfcm_pkg::TILE_W-1:0] col_lut [LUT_DEPTH];
  logic [vfcm_pkg::TILE_W-1:0] row_lut [LUT_DEPTH];

  vfcm_store #(
    .CHUNK_DIM(CHUNK_DIM)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  vfcm_ctrl #(
    .CHUNK_DIM(CHUNK_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (in_i),
    .busy_o      (busy_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .quad_o      (quad),
    .quad_valid_o(quad_valid),
    .block_o     (block)
  );

  // block id clamped to the atlas, split into column and row
  for (genvar i = 0; i < LUT_DEPTH; i++) begin : g_tile
    localparam int TI = (i > MAX_TILE) ? MAX_TILE : i;
    assign col_lut[i] = vfcm_pkg::TILE_W'(TI % ATLAS_COLS);
    assign row_lut[i] = vfcm_pkg::TILE_W'(TI / ATLAS_COLS);
  end

  always_comb begin
    result_o.corner_x      = quad.corner_x;
    result_o.corner_y      = quad.corner_y;
    result_o.corner_z      = quad.corner_z;
    result_o.face_axis     = quad.face_axis;
    result_o.positive_side = quad.positive_side;
    result_o.tile_col      = col_lut[block];
    result_o.tile_row      = row_lut[block];
    result_o.base_vertex   = quad.base_vertex;
    result_o.last          = quad.last;
  end

  assign result_valid_o = quad_valid;

`ifndef ASSERT_OFF
  // quads of one voxel come out back to back
  a_quads_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("quad stream of a voxel broke before last");

  // base vertex steps by one quad inside a voxel's stream
  a_base_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=>
      result_o.base_vertex == $past(result_o.base_vertex) + vfcm_pkg::VERTS_PER_QUAD)
    else $error("base vertex did not advance by one quad");

  // a quad only follows a busy cycle
  a_quad_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("quad without a mesh command in progress");
`endif

endmodule

FILE: test/tb_top.sv
// testbench for the voxel face culling mesher: random command stream, quad predictor, checker
`timescale 1ns / 1ps

module tb_top;

  localparam int DIM      = vfcm_pkg::CHUNK_DIM_DEF;
  localparam int CELLS    = DIM * DIM * DIM;
  localparam int TILE_MAX = vfcm_pkg::ATLAS_COLS_DEF * vfcm_pkg::ATLAS_ROWS_DEF - 1;
  localparam int RAND_CMDS = 380;
  // back to back meshes of one isolated voxel
  localparam int ISO_MESHES = 4;

  typedef struct {
    vfcm_pkg::in_item_t cmd;
    int unsigned        idle;
  } pend_cmd_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i = 1'b0;
  vfcm_pkg::in_item_t  in_i = '0;
  logic                busy_o;
  vfcm_pkg::out_item_t result_o;
  logic                result_valid_o;

  pend_cmd_t           cmd_q[$];
  vfcm_pkg::out_item_t due_quads[$];
  int unsigned         idle_left;
  int unsigned         err_cnt = 0;

  // predictor state
  logic [vfcm_pkg::BLOCK_W-1:0] chunk_copy [CELLS];
  logic [vfcm_pkg::BASE_W-1:0]  next_vertex = '0;

  // stimulus bookkeeping: which cells have been written so far
  bit          vox_known [CELLS];
  int unsigned cmd_count = 0;
  int unsigned quiet_left = 0;
  int          clu_x, clu_y, clu_z;

  voxel_face_culling_mesher_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_i           (in_i),
    .busy_o         (busy_o),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int cell_at(int x, int y, int z);
    return (x * DIM + y) * DIM + z;
  endfunction

  function automatic bit in_chunk(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < DIM && y < DIM && z < DIM;
  endfunction

  function automatic bit cell_solid(int x, int y, int z);
    if (!in_chunk(x, y, z)) return 1'b0;
    return chunk_copy[cell_at(x, y, z)] != '0;
  endfunction

  function automatic string fmt_quad(vfcm_pkg::out_item_t q);
    return $sformatf("corner=(%0d,%0d,%0d) axis=%0d pos=%0b tile=(%0d,%0d) base=%0d last=%0b",
                     q.corner_x, q.corner_y, q.corner_z, q.face_axis, q.positive_side,
                     q.tile_col, q.tile_row, q.base_vertex, q.last);
  endfunction

  // expected quads of one accepted command, appended to due_quads
  function automatic void predict_quads(vfcm_pkg::in_item_t cmd);
    logic [vfcm_pkg::BLOCK_W-1:0] blk;
    int                           tile;
    int                           made;
    int                           pos [3];
    int                           nb [3];
    int                           cor [3];
    vfcm_pkg::out_item_t          q;
    made = 0;
    pos[0] = cmd.voxel_x;
    pos[1] = cmd.voxel_y;
    pos[2] = cmd.voxel_z;
    case (vfcm_pkg::mode_e'(cmd.mode))
      vfcm_pkg::MODE_NEW: next_vertex = '0;
      vfcm_pkg::MODE_WRITE: chunk_copy[cell_at(pos[0], pos[1], pos[2])] = cmd.block_value;
      vfcm_pkg::MODE_MESH: begin
        blk = chunk_copy[cell_at(pos[0], pos[1], pos[2])];
        if (blk != '0) begin
          tile = (int'(blk) > TILE_MAX) ? TILE_MAX : int'(blk);
          for (int ax = 0; ax < 3; ax++) begin
            for (int sd = 0; sd < 2; sd++) begin
              nb = pos;
              cor = pos;
              nb[ax] += sd ? 1 : -1;
              cor[ax] += sd;
              if (!cell_solid(nb[0], nb[1], nb[2])) begin
                q.corner_x      = vfcm_pkg::CORNER_W'(cor[0]);
                q.corner_y      = vfcm_pkg::CORNER_W'(cor[1]);
                q.corner_z      = vfcm_pkg::CORNER_W'(cor[2]);
                q.face_axis     = vfcm_pkg::AXIS_W'(ax);
                q.positive_side = (sd == 1);
                q.tile_col      = vfcm_pkg::TILE_W'(tile % vfcm_pkg::ATLAS_COLS_DEF);
                q.tile_row      = vfcm_pkg::TILE_W'(tile / vfcm_pkg::ATLAS_COLS_DEF);
                q.base_vertex   = next_vertex;
                q.last          = 1'b0;
                due_quads.insert(due_quads.size(), q);
                next_vertex = next_vertex + vfcm_pkg::VERTS_PER_QUAD;
                made++;
              end
            end
          end
          if (made > 0) due_quads[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // idle cycles before a command: mostly none or short, a few long, some quiet stretches
  function automatic int unsigned make_gap();
    int unsigned r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  function automatic int rand_block();
    if ($urandom_range(0, 99) < 40) return 0;
    return $urandom_range(1, 255);
  endfunction

  function automatic void push_cmd(vfcm_pkg::mode_e m, int x, int y, int z, int blk,
                                   int unsigned idle);
    pend_cmd_t p;
    p.cmd.mode        = m;
    p.cmd.voxel_x     = vfcm_pkg::COORD_W'(x);
    p.cmd.voxel_y     = vfcm_pkg::COORD_W'(y);
    p.cmd.voxel_z     = vfcm_pkg::COORD_W'(z);
    p.cmd.block_value = vfcm_pkg::BLOCK_W'(blk);
    p.idle            = idle;
    cmd_q.insert(cmd_q.size(), p);
    if (m == vfcm_pkg::MODE_WRITE) vox_known[cell_at(x, y, z)] = 1'b1;
    if (m != vfcm_pkg::MODE_RSVD) cmd_count++;
  endfunction

  // a mesh command reads the voxel and its neighbors, so write any that are still unknown
  function automatic void mesh_at(int x, int y, int z);
    int n [3];
    for (int c = 0; c < 7; c++) begin
      n[0] = x;
      n[1] = y;
      n[2] = z;
      if (c > 0) n[(c - 1) / 2] += ((c - 1) % 2) ? 1 : -1;
      if (in_chunk(n[0], n[1], n[2]) && !vox_known[cell_at(n[0], n[1], n[2])])
        push_cmd(vfcm_pkg::MODE_WRITE, n[0], n[1], n[2], rand_block(), make_gap());
    end
    push_cmd(vfcm_pkg::MODE_MESH, x, y, z, $urandom_range(0, 255), make_gap());
  endfunction

  function automatic int edge_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 50) return DIM - 4;
    return $urandom_range(0, DIM - 4);
  endfunction

  function automatic void build_stimulus();
    int unsigned base_cnt;
    int unsigned r;
    // directed: corners, atlas extremes and clamp, empty voxel, reserved mode, restart
    push_cmd(vfcm_pkg::MODE_NEW, 31, 31, 31, 255, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 0, 0, 0, 4, make_gap());
    push_cmd(vfcm_pkg::MODE_WRITE, 1, 0, 0, 0, make_gap());
    push_cmd(vfcm_pkg::MODE_WRITE, 0, 1, 0, 0, make_gap());
    push_cmd(vfcm_pkg::MODE_WRITE, 0, 0, 1, 0, make_gap());
    mesh_at(0, 0, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 31, 31, 31, 255, make_gap());
    push_cmd(vfcm_pkg::MODE_WRITE, 30, 31, 31, 16, make_gap());
    push_cmd(vfcm_pkg::MODE_WRITE, 31, 30, 31, 0, make_gap());
    push_cmd(vfcm_pkg::MODE_WRITE, 31, 31, 30, 0, make_gap());
    mesh_at(31, 31, 31);
    mesh_at(30, 31, 31);
    mesh_at(0, 1, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 1, 0, 0, 15, make_gap());
    mesh_at(0, 0, 0);
    mesh_at(1, 0, 0);
    push_cmd(vfcm_pkg::MODE_RSVD, 31, 31, 31, 255, make_gap());
    push_cmd(vfcm_pkg::MODE_RSVD, 0, 0, 0, 0, make_gap());
    push_cmd(vfcm_pkg::MODE_NEW, 0, 0, 0, 0, make_gap());
    mesh_at(0, 0, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 0, 0, 0, 0, make_gap());
    mesh_at(0, 0, 0);

    // one isolated voxel meshed repeatedly, back to back
    push_cmd(vfcm_pkg::MODE_WRITE, 16, 16, 16, 6, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 15, 16, 16, 0, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 17, 16, 16, 0, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 16, 15, 16, 0, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 16, 17, 16, 0, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 16, 16, 15, 0, 0);
    push_cmd(vfcm_pkg::MODE_WRITE, 16, 16, 17, 0, 0);
    push_cmd(vfcm_pkg::MODE_NEW, 16, 16, 16, 0, 0);
    for (int i = 0; i < ISO_MESHES; i++) push_cmd(vfcm_pkg::MODE_MESH, 16, 16, 16, 0, 0);

    // random: mostly writes and meshes around a cluster so faces get hidden and exposed
    base_cnt = cmd_count;
    clu_x = edge_coord();
    clu_y = edge_coord();
    clu_z = edge_coord();
    while (cmd_count - base_cnt < RAND_CMDS) begin
      if ($urandom_range(0, 99) < 8) begin
        clu_x = edge_coord();
        clu_y = edge_coord();
        clu_z = edge_coord();
      end
      r = $urandom_range(0, 99);
      if (r < 5)
        push_cmd(vfcm_pkg::MODE_RSVD, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 255), make_gap());
      else if (r < 9)
        push_cmd(vfcm_pkg::MODE_NEW, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 255), make_gap());
      else if (r < 28)
        push_cmd(vfcm_pkg::MODE_WRITE, clu_x + $urandom_range(0, 3),
                 clu_y + $urandom_range(0, 3), clu_z + $urandom_range(0, 3),
                 rand_block(), make_gap());
      else if (r < 38)
        push_cmd(vfcm_pkg::MODE_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 255), make_gap());
      else if (r < 45)
        mesh_at($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      else
        mesh_at(clu_x + $urandom_range(0, 3), clu_y + $urandom_range(0, 3),
                clu_z + $urandom_range(0, 3));
    end
  endfunction

  // driver: presents queued commands, holding each until the transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      in_i      <= '0;
      idle_left <= 0;
    end else if (!start_i || !busy_o) begin
      if (idle_left > 0) begin
        start_i   <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (cmd_q.size() == 0) begin
        start_i <= 1'b0;
      end else if (cmd_q[0].idle > 0) begin
        start_i   <= 1'b0;
        idle_left <= cmd_q[0].idle - 1;
        cmd_q[0].idle = 0;
      end else begin
        start_i <= 1'b1;
        in_i    <= cmd_q[0].cmd;
        void'(cmd_q.pop_front());
      end
    end
  end

  // monitor: check the quad of this cycle first, then predict for a transfer at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        if (due_quads.size() == 0) begin
          $display("%0t: unexpected quad, expected none, got %s", $time, fmt_quad(result_o));
          err_cnt++;
        end else begin
          if (result_o !== due_quads[0]) begin
            $display("%0t: quad mismatch, expected %s, got %s", $time,
                     fmt_quad(due_quads[0]), fmt_quad(result_o));
            err_cnt++;
          end
          void'(due_quads.pop_front());
        end
      end
      if (start_i && busy_o === 1'b0) predict_quads(in_i);
    end
  end

  initial begin
    rst_ni = 1'b0;
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (cmd_q.size() != 0 || start_i || idle_left != 0);
    while (due_quads.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
    if (err_cnt == 0 && due_quads.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("%0t: timeout, %0d commands and %0d quads still pending", $time,
             cmd_q.size(), due_quads.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
